/* rtl/core/dpr_pkg.sv */
`default_nettype none

package dpr_pkg;

  // Payload buffer geometry
  localparam int BUF_DEPTH = 512;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // Register reset
  localparam logic [8:0] MAX_PAYLOAD_RST = 9'd399;

  // Protocol characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Input op codes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HIGH    = 2'd2,
    PH_LOW     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_NACK  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       packet_ready;
    logic [1:0] payload_start;
    logic [8:0] payload_length;
    logic [7:0] read_data;
    logic       last;
  } out_item_t;

  // One classified item from the front to the back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       seq;
    logic [8:0] addr;
    logic [7:0] data;
    logic [8:0] len;
    logic [7:0] seq0;
    logic [7:0] seq1;
  } cmd_t;

  // Hex digit value; an invalid digit is -1 modulo 256
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h61 + 8'd10;
    end else if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h41 + 8'd10;
    end
    return v;
  endfunction

  // Position lies inside the payload buffer
  function automatic logic idx_in_buf(input logic [8:0] idx);
    return 32'(idx) < BUF_DEPTH;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dpr_front.sv */
`default_nettype none

module dpr_front
  import dpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_item,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,
  output logic            cmd_push,
  output cmd_t            cmd,
  input  wire logic       cmd_full
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  seq0_r, seq0_nxt;
  logic [7:0]  seq1_r, seq1_nxt;
  logic [7:0]  seq2_r, seq2_nxt;
  logic [8:0]  max_r;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  dv;
  logic [7:0]  sent;
  logic [8:0]  limit;
  logic [8:0]  count_inc;
  logic        seq_hit;

  // Accept whenever the command queue has room
  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign b         = in_item.rx_byte;
  assign dv        = digit_value(b);
  assign sent      = high_r + dv;
  assign limit     = (max_r == 9'd0) ? 9'd1 : max_r;
  assign count_inc = count_r + 9'd1;
  assign seq_hit   = (count_r >= 9'd3) && (seq2_r == CH_COLON);

  // Next state of the packet parser
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    high_nxt  = high_r;
    seq0_nxt  = seq0_r;
    seq1_nxt  = seq1_r;
    seq2_nxt  = seq2_r;
    if (accept && in_item.op == OP_RX) begin
      case (phase_r)
        PH_HUNT: begin
          if (b == CH_DOLLAR) begin
            phase_nxt = PH_PAYLOAD;
            sum_nxt   = 8'd0;
            count_nxt = 9'd0;
          end
        end
        PH_PAYLOAD: begin
          if (b == CH_DOLLAR) begin
            sum_nxt   = 8'd0;
            count_nxt = 9'd0;
          end else if (b == CH_HASH) begin
            phase_nxt = PH_HIGH;
          end else begin
            sum_nxt   = sum_r + b;
            count_nxt = count_inc;
            // shadow the first three stored bytes for the sequence check
            if (count_r == 9'd0) seq0_nxt = b;
            if (count_r == 9'd1) seq1_nxt = b;
            if (count_r == 9'd2) seq2_nxt = b;
            if (count_inc >= limit) phase_nxt = PH_HUNT;
          end
        end
        PH_HIGH: begin
          high_nxt  = {dv[3:0], 4'h0};
          phase_nxt = PH_LOW;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Classify the accepted item into a command
  always_comb begin
    cmd_push = 1'b0;
    cmd      = '0;
    cmd.len  = count_r;
    cmd.seq0 = seq0_r;
    cmd.seq1 = seq1_r;
    if (accept) begin
      if (in_item.op == OP_READ) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_READ;
        cmd.addr = in_item.read_index;
      end else begin
        case (phase_r)
          PH_PAYLOAD: begin
            if (b != CH_DOLLAR && b != CH_HASH && idx_in_buf(count_r)) begin
              cmd_push = 1'b1;
              cmd.kind = CMD_WRITE;
              cmd.addr = count_r;
              cmd.data = b;
            end
          end
          PH_LOW: begin
            cmd_push = 1'b1;
            if (sent != sum_r) begin
              cmd.kind = CMD_NACK;
            end else begin
              cmd.kind = CMD_ACK;
              cmd.seq  = seq_hit;
            end
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 8'd0;
      count_r <= 9'd0;
      high_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      high_r  <= high_nxt;
    end
  end

  // Sequence byte shadows
  always_ff @(posedge clk) begin
    seq0_r <= seq0_nxt;
    seq1_r <= seq1_nxt;
    seq2_r <= seq2_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dpr_cmd_fifo.sv */
`default_nettype none

module dpr_cmd_fifo
  import dpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      empty
);

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_PTR_W:0]   cnt_r;
  logic                 do_push, do_pop;

  assign full    = (32'(cnt_r) == CMD_DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rd_ptr_r];

  // Store the item at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == CMD_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == CMD_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dpr_back.sv */
`default_nettype none

module dpr_back
  import dpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_empty,
  input  wire cmd_t      cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_item
);

  logic [7:0]  mem [BUF_DEPTH];
  logic [7:0]  rd_data_r;

  logic        s1_valid_r;
  cmd_t        s1_r;
  logic [1:0]  s1_step_r;
  logic        s1_inbuf_r;

  logic        out_valid_r;
  out_item_t   out_r;

  logic        out_free;
  logic        s1_emit;
  logic        s1_final;
  logic        s1_free;
  logic        s1_load;
  logic        is_write;
  logic        mem_we;
  out_item_t   res;

  assign is_write = (cmd.kind == CMD_WRITE);
  assign out_free = !out_valid_r || pop;
  assign s1_emit  = s1_valid_r && out_free;
  assign s1_final = !(s1_r.kind == CMD_ACK && s1_r.seq) || (s1_step_r == 2'd2);
  assign s1_free  = !s1_valid_r || (s1_emit && s1_final);
  assign cmd_pop  = !cmd_empty && (is_write || s1_free);
  assign s1_load  = cmd_pop && !is_write;
  assign mem_we   = cmd_pop && is_write;

  // Payload buffer: write in queue order, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[ADDR_W'(cmd.addr)] <= cmd.data;
  end

  always_ff @(posedge clk) begin
    if (s1_load && cmd.kind == CMD_READ) rd_data_r <= mem[ADDR_W'(cmd.addr)];
  end

  // Hold the command being carried out
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r       <= cmd;
      s1_inbuf_r <= idx_in_buf(cmd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_step_r  <= 2'd0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        s1_step_r  <= 2'd0;
      end else if (s1_emit && s1_final) begin
        s1_valid_r <= 1'b0;
        s1_step_r  <= 2'd0;
      end else if (s1_emit) begin
        s1_step_r  <= s1_step_r + 2'd1;
      end
    end
  end

  // Build the result for the current step
  always_comb begin
    res = '0;
    case (s1_r.kind)
      CMD_READ: begin
        res.read_data = s1_inbuf_r ? rd_data_r : 8'd0;
        res.last      = 1'b1;
      end
      CMD_NACK: begin
        res.tx_valid = 1'b1;
        res.tx_char  = CH_MINUS;
        res.last     = 1'b1;
      end
      CMD_ACK: begin
        res.tx_valid       = 1'b1;
        res.packet_ready   = 1'b1;
        res.payload_length = s1_r.len;
        res.payload_start  = s1_r.seq ? 2'd3 : 2'd0;
        res.last           = s1_final;
        case (s1_step_r)
          2'd1:    res.tx_char = s1_r.seq0;
          2'd2:    res.tx_char = s1_r.seq1;
          default: res.tx_char = CH_PLUS;
        endcase
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Output register parts the back from the result consumer
  always_ff @(posedge clk) begin
    if (s1_emit) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  // A step past the first belongs only to a sequenced acknowledge
  a_step_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_step_r != 2'd0) |-> (s1_valid_r && s1_r.kind == CMD_ACK && s1_r.seq))
    else $error("step counter outside sequenced acknowledge");

  // A buffer write never loads the execute stage
  a_write_noload: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !s1_load)
    else $error("write command loaded the execute stage");

  // A ready packet result is always something to transmit
  a_ready_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.packet_ready) |-> out_r.tx_valid)
    else $error("packet result without transmit");

  // The execute stage never drops its command while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("execute stage lost a stalled command");

endmodule

`default_nettype wire

/* rtl/core/debug_packet_receiver.sv */
`default_nettype none

// Debug packet receiver. Takes serial bytes of "$<payload>#<hi><lo>" packets
// and read requests for stored payload bytes, one item per clock cycle
// while full is low; items that produce results (read, checksum low digit)
// reach the result ports through the command queue, execute stage and output
// register, one result per cycle while pop keeps up. A good packet with a
// sequence id ("ss:") yields three results ('+', then the two sequence
// bytes) and occupies the result side while it emits them; the four-entry
// command queue in front of it absorbs that burst. The payload buffer is a
// single-port memory with a registered read; its contents are undefined
// after reset and need no clearing pass. The user must write max_payload
// through cfg_we/cfg_wdata only while the block is idle (not enforced).
module debug_packet_receiver
  import dpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_item,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);

  logic cmd_push;
  cmd_t cmd_wr;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_rd;
  logic cmd_empty;

  // Parse and classify incoming items
  dpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_push  (cmd_push),
    .cmd       (cmd_wr),
    .cmd_full  (cmd_full)
  );

  // Decouple front and back
  dpr_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_cmd (cmd_rd),
    .empty  (cmd_empty)
  );

  // Carry out buffer writes, reads and acknowledges
  dpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
